// ===== design/srmc_pkg.sv =====
// Shared types and constants for the sixteen-bit register machine core.
package srmc_pkg;

  typedef struct packed {
    logic        operation;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [15:0] console_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic        halted;
    logic        console_out_valid;
    logic [7:0]  console_out_char;
    logic        console_in_taken;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_JAL  = 4'd0,
    OP_MOV  = 4'd1,
    OP_SET  = 4'd2,
    OP_LOAD = 4'd3,
    OP_STOR = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_MUL  = 4'd7,
    OP_DIV  = 4'd8,
    OP_SHL  = 4'd9,
    OP_SHR  = 4'd10,
    OP_AND  = 4'd11,
    OP_OR   = 4'd12,
    OP_NOT  = 4'd13,
    OP_PRD  = 4'd14,
    OP_PWR  = 4'd15
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_FETCH,
    ST_RDA,
    ST_RDB,
    ST_LDW,
    ST_DIVW,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_LOADITEM,
    P_FETCH,
    P_LD,
    P_ST
  } purpose_t;

  localparam logic [15:0] PORT_CONSOLE  = 16'd0;
  localparam logic [15:0] PORT_HALT     = 16'd1;
  localparam logic [15:0] PORT_D0_COUNT = 16'd2;
  localparam logic [15:0] PORT_D0_SECT  = 16'd3;
  localparam logic [15:0] PORT_D0_ADDR  = 16'd4;
  localparam logic [15:0] PORT_D1_COUNT = 16'd5;
  localparam logic [15:0] PORT_D1_SECT  = 16'd6;
  localparam logic [15:0] PORT_D1_ADDR  = 16'd7;

  localparam logic CFG_D0_COUNT = 1'b0;
  localparam logic CFG_D1_COUNT = 1'b1;

endpackage

// ===== design/srmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/srmc_div.sv =====
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
module srmc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);
  logic [15:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  always_comb begin
    shifted  = {rem_r, q_r[15]};
    trial    = shifted - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (trial[16]) begin
        rem_nxt = shifted[15:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[14:0], 1'b1};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd16;
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule

// ===== design/sixteen_bit_register_machine_core.sv =====
// Sixteen-bit register machine core: sequencer, register file, word memory, divider.
// States per item: load item IDLE, INDEX, DONE; halted step IDLE, DONE; step IDLE, INDEX,
// FETCH, RDA, RDB, DONE; a store adds INDEX after RDB, a memory load INDEX and LDW, a divide
// DIVW. If MEM_WORDS is not a power of two, INDEX waits for the registered address reduction.
// A stalled result holds the core until the output register frees. Throughput: one item at a
// time, bounded by the bit-serial divider and single memory port. Reset: synchronous, active
// low; then a clearing pass zeroes memory and registers, during which no beat is accepted.
module sixteen_bit_register_machine_core #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srmc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import srmc_pkg::*;

  localparam int  AW   = $clog2(MEM_WORDS);
  localparam bit  POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam logic [15:0] MEM_DIVISOR = 16'(MEM_WORDS);
  localparam logic [24:0] MEM_RECIP   = 25'((64'd1 << 32) / 64'(MEM_WORDS) + 64'd1);

  state_t      state_r, state_nxt;
  purpose_t    purp_r, purp_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] ir_r, ir_nxt;
  logic [15:0] a_r, a_nxt;
  logic [15:0] b_r, b_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] ldata_r, ldata_nxt;
  logic [15:0] cin_r, cin_nxt;
  logic        cov_r, cov_nxt;
  logic [7:0]  coc_r, coc_nxt;
  logic        cit_r, cit_nxt;
  logic [15:0] d0cnt_r, d1cnt_r;
  logic [15:0] d0sec_r, d0sec_nxt, d0adr_r, d0adr_nxt;
  logic [15:0] d1sec_r, d1sec_nxt, d1adr_r, d1adr_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        idx_rdy_r, idx_rdy_nxt;
  logic [8:0]  rq_r, rq_nxt;
  logic [15:0] idx_mod;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, idx;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          rf_we;
  logic [3:0]    rf_waddr, rf_raddr;
  logic [15:0]   rf_wdata, rf_rdata;

  logic        div_start, div_busy;
  logic [15:0] div_a, div_b, div_q;

  opcode_t     opc;
  logic [15:0] pval;
  logic [31:0] prod;

  srmc_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  srmc_ram #(.WIDTH(16), .DEPTH(16)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  srmc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  assign opc  = opcode_t'(ir_r[15:12]);
  assign prod = a_r * rf_rdata;
  // reciprocal quotient of the address, registered, then back-multiply for the remainder
  assign rq_nxt  = 9'((41'(addr_r) * 41'(MEM_RECIP)) >> 32);
  assign idx_mod = addr_r - 16'(rq_r * MEM_DIVISOR);
  assign idx     = POW2 ? addr_r[AW-1:0] : idx_mod[AW-1:0];

  always_comb begin
    unique case (a_r)
      PORT_CONSOLE:  pval = cin_r;
      PORT_D0_COUNT: pval = d0cnt_r;
      PORT_D0_SECT:  pval = d0sec_r;
      PORT_D0_ADDR:  pval = d0adr_r;
      PORT_D1_COUNT: pval = d1cnt_r;
      PORT_D1_SECT:  pval = d1sec_r;
      PORT_D1_ADDR:  pval = d1adr_r;
      default:       pval = 16'd0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    purp_nxt    = purp_r;
    clr_nxt     = clr_r;
    pc_nxt      = pc_r;
    halt_nxt    = halt_r;
    ir_nxt      = ir_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    addr_nxt    = addr_r;
    ldata_nxt   = ldata_r;
    cin_nxt     = cin_r;
    cov_nxt     = cov_r;
    coc_nxt     = coc_r;
    cit_nxt     = cit_r;
    d0sec_nxt   = d0sec_r;
    d0adr_nxt   = d0adr_r;
    d1sec_nxt   = d1sec_r;
    d1adr_nxt   = d1adr_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    idx_rdy_nxt = (state_r == ST_INDEX);
    in_stall    = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = ldata_r;
    mem_raddr   = idx;
    rf_we       = 1'b0;
    rf_waddr    = ir_r[11:8];
    rf_wdata    = 16'd0;
    rf_raddr    = ir_r[7:4];
    div_start   = 1'b0;
    div_a       = a_r;
    div_b       = rf_rdata;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[AW-1:0];
        mem_wdata = 16'd0;
        rf_we     = 1'b1;
        rf_waddr  = clr_r[3:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cov_nxt = 1'b0;
          coc_nxt = 8'd0;
          cit_nxt = 1'b0;
          cin_nxt = in_data.console_in;
          if (!in_data.operation) begin
            addr_nxt  = in_data.load_address;
            ldata_nxt = in_data.load_data;
            purp_nxt  = P_LOADITEM;
            state_nxt = ST_INDEX;
          end else if (halt_r) begin
            state_nxt = ST_DONE;
          end else begin
            addr_nxt  = pc_r;
            purp_nxt  = P_FETCH;
            state_nxt = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        if (POW2 || idx_rdy_r) begin
          unique case (purp_r)
            P_LOADITEM: begin
              mem_we    = 1'b1;
              state_nxt = ST_DONE;
            end
            P_FETCH: state_nxt = ST_FETCH;
            P_LD:    state_nxt = ST_LDW;
            P_ST: begin
              mem_we    = 1'b1;
              mem_wdata = b_r;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        ir_nxt    = mem_rdata;
        rf_raddr  = mem_rdata[3:0];
        pc_nxt    = pc_r + 16'd1;
        state_nxt = ST_RDA;
      end
      ST_RDA: begin
        a_nxt     = rf_rdata;
        rf_raddr  = ir_r[7:4];
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        b_nxt     = rf_rdata;
        state_nxt = ST_DONE;
        unique case (opc)
          OP_JAL: begin
            if (rf_rdata != 16'd0) begin
              pc_nxt   = a_r;
              rf_we    = 1'b1;
              rf_wdata = pc_r;
            end
          end
          OP_MOV: begin rf_we = 1'b1; rf_wdata = a_r; end
          OP_SET: begin rf_we = 1'b1; rf_wdata = {8'd0, ir_r[7:0]}; end
          OP_LOAD, OP_STOR: begin
            addr_nxt  = a_r;
            purp_nxt  = (opc == OP_LOAD) ? P_LD : P_ST;
            state_nxt = ST_INDEX;
          end
          OP_ADD: begin rf_we = 1'b1; rf_wdata = a_r + rf_rdata; end
          OP_SUB: begin rf_we = 1'b1; rf_wdata = a_r - rf_rdata; end
          OP_MUL: begin rf_we = 1'b1; rf_wdata = prod[15:0]; end
          OP_DIV: begin
            div_a     = a_r;
            div_b     = rf_rdata;
            div_start = 1'b1;
            state_nxt = ST_DIVW;
          end
          OP_SHL: begin rf_we = 1'b1; rf_wdata = a_r << ir_r[7:4]; end
          OP_SHR: begin rf_we = 1'b1; rf_wdata = a_r >> ir_r[7:4]; end
          OP_AND: begin rf_we = 1'b1; rf_wdata = a_r & rf_rdata; end
          OP_OR:  begin rf_we = 1'b1; rf_wdata = a_r | rf_rdata; end
          OP_NOT: begin rf_we = 1'b1; rf_wdata = ~a_r; end
          OP_PRD: begin
            rf_we    = 1'b1;
            rf_wdata = pval;
            cit_nxt  = (a_r == PORT_CONSOLE);
          end
          OP_PWR: begin
            unique case (a_r)
              PORT_CONSOLE: begin cov_nxt = 1'b1; coc_nxt = rf_rdata[7:0]; end
              PORT_HALT:    halt_nxt  = (rf_rdata != 16'd0);
              PORT_D0_SECT: d0sec_nxt = rf_rdata;
              PORT_D0_ADDR: d0adr_nxt = rf_rdata;
              PORT_D1_SECT: d1sec_nxt = rf_rdata;
              PORT_D1_ADDR: d1adr_nxt = rf_rdata;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_LDW: begin
        rf_we     = 1'b1;
        rf_wdata  = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DIVW: begin
        if (!div_busy) begin
          rf_we     = 1'b1;
          rf_wdata  = div_q;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!ov_r || !out_stall) begin
          ov_nxt                   = 1'b1;
          od_nxt.program_counter   = pc_r;
          od_nxt.halted            = halt_r;
          od_nxt.console_out_valid = cov_r;
          od_nxt.console_out_char  = coc_r;
          od_nxt.console_in_taken  = cit_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      d0sec_r   <= '0;
      d0adr_r   <= '0;
      d1sec_r   <= '0;
      d1adr_r   <= '0;
      d0cnt_r   <= '0;
      d1cnt_r   <= '0;
      ov_r      <= 1'b0;
      idx_rdy_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
      d0sec_r   <= d0sec_nxt;
      d0adr_r   <= d0adr_nxt;
      d1sec_r   <= d1sec_nxt;
      d1adr_r   <= d1adr_nxt;
      ov_r      <= ov_nxt;
      idx_rdy_r <= idx_rdy_nxt;
      if (cfg_we && cfg_index == CFG_D0_COUNT) begin
        d0cnt_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_D1_COUNT) begin
        d1cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    purp_r  <= purp_nxt;
    ir_r    <= ir_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    addr_r  <= addr_nxt;
    ldata_r <= ldata_nxt;
    cin_r   <= cin_nxt;
    cov_r   <= cov_nxt;
    coc_r   <= coc_nxt;
    cit_r   <= cit_nxt;
    od_r    <= od_nxt;
    rq_r    <= rq_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sixteen-bit register machine core.

class core_scoreboard;
  srmc_pkg::out_item_t expected_q[$];
  logic [15:0] pc;
  logic [15:0] regs [16];
  logic [15:0] mem [65536];
  logic        halted;
  logic [15:0] d0_sect, d0_addr, d1_sect, d1_addr;
  logic [15:0] d0_count, d1_count;
  int          mismatches;

  function new();
    pc = '0;
    halted = 1'b0;
    d0_sect = '0; d0_addr = '0; d1_sect = '0; d1_addr = '0;
    d0_count = '0; d1_count = '0;
    mismatches = 0;
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
  endfunction

  // Advance the machine by one accepted beat and queue the result it must produce.
  function void note_input(srmc_pkg::in_item_t it);
    srmc_pkg::out_item_t r;
    srmc_pkg::opcode_t   opc;
    logic [15:0] word, a, b, link;
    logic [3:0]  d, s1, s0;
    r = '0;
    if (!it.operation) begin
      mem[it.load_address] = it.load_data;
    end else if (!halted) begin
      word = mem[pc];
      opc = srmc_pkg::opcode_t'(word[15:12]);
      d = word[11:8];
      s1 = word[7:4];
      s0 = word[3:0];
      a = regs[s0];
      b = regs[s1];
      pc = pc + 16'd1;
      case (opc)
        srmc_pkg::OP_JAL: begin
          if (b != 0) begin
            link = pc;
            pc = a;
            regs[d] = link;
          end
        end
        srmc_pkg::OP_MOV:  regs[d] = a;
        srmc_pkg::OP_SET:  regs[d] = {8'h00, s1, s0};
        srmc_pkg::OP_LOAD: regs[d] = mem[a];
        srmc_pkg::OP_STOR: mem[a] = b;
        srmc_pkg::OP_ADD:  regs[d] = a + b;
        srmc_pkg::OP_SUB:  regs[d] = a - b;
        srmc_pkg::OP_MUL:  regs[d] = 16'(a * b);
        srmc_pkg::OP_DIV:  regs[d] = (b != 0) ? a / b : 16'hFFFF;
        srmc_pkg::OP_SHL:  regs[d] = 16'(a << s1);
        srmc_pkg::OP_SHR:  regs[d] = a >> s1;
        srmc_pkg::OP_AND:  regs[d] = a & b;
        srmc_pkg::OP_OR:   regs[d] = a | b;
        srmc_pkg::OP_NOT:  regs[d] = ~a;
        srmc_pkg::OP_PRD: begin
          case (a)
            srmc_pkg::PORT_CONSOLE: begin
              regs[d] = it.console_in;
              r.console_in_taken = 1'b1;
            end
            srmc_pkg::PORT_D0_COUNT: regs[d] = d0_count;
            srmc_pkg::PORT_D0_SECT:  regs[d] = d0_sect;
            srmc_pkg::PORT_D0_ADDR:  regs[d] = d0_addr;
            srmc_pkg::PORT_D1_COUNT: regs[d] = d1_count;
            srmc_pkg::PORT_D1_SECT:  regs[d] = d1_sect;
            srmc_pkg::PORT_D1_ADDR:  regs[d] = d1_addr;
            default:                 regs[d] = '0;
          endcase
        end
        default: begin
          case (a)
            srmc_pkg::PORT_CONSOLE: begin
              r.console_out_valid = 1'b1;
              r.console_out_char = b[7:0];
            end
            srmc_pkg::PORT_HALT:    halted = (b != 0);
            srmc_pkg::PORT_D0_SECT: d0_sect = b;
            srmc_pkg::PORT_D0_ADDR: d0_addr = b;
            srmc_pkg::PORT_D1_SECT: d1_sect = b;
            srmc_pkg::PORT_D1_ADDR: d1_addr = b;
            default: ;
          endcase
        end
      endcase
    end
    r.program_counter = pc;
    r.halted = halted;
    expected_q.push_back(r);
  endfunction

  function void check_result(srmc_pkg::out_item_t act);
    srmc_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %p", act);
      return;
    end
    exp = expected_q.pop_front();
    if (act.program_counter !== exp.program_counter || act.halted !== exp.halted ||
        act.console_out_valid !== exp.console_out_valid ||
        act.console_out_char !== exp.console_out_char ||
        act.console_in_taken !== exp.console_in_taken) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, act);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srmc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  core_scoreboard sb;
  int  burst_left;
  bit  hold_req;

  sixteen_bit_register_machine_core i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: runs of free flow, random stalls and periodic stalls, plus one long hold.
  initial begin
    int mode, len, k;
    out_stall = 1'b0;
    k = 0;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(10, 80);
      repeat (len) begin
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (300) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          k++;
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= (k % 4 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_beat(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] data);
    in_item_t it;
    it.operation = 1'b0;
    it.load_address = addr;
    it.load_data = data;
    it.console_in = 16'($urandom());
    send_beat(it);
  endtask

  task automatic step(logic [15:0] cin);
    in_item_t it;
    it.operation = 1'b1;
    it.load_address = 16'($urandom());
    it.load_data = 16'($urandom());
    it.console_in = cin;
    send_beat(it);
  endtask

  // Place an instruction at the current pc and execute it.
  task automatic run_insn(opcode_t op, logic [3:0] d, logic [3:0] s1, logic [3:0] s0,
                          logic [15:0] cin);
    load_word(sb.pc, {op, d, s1, s0});
    step(cin);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable after the last one.
  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_D0_COUNT) sb.d0_count = val;
    else sb.d1_count = val;
  endtask

  task automatic random_insn();
    opcode_t    op;
    logic [3:0] d, s1, s0;
    op = opcode_t'($urandom_range(0, 15));
    d = 4'($urandom());
    s1 = 4'($urandom());
    s0 = 4'($urandom());
    // Give port accesses a real port address most of the time.
    if ((op == OP_PRD || op == OP_PWR) && $urandom_range(0, 9) < 7)
      run_insn(OP_SET, s0, 4'h0, 4'($urandom_range(0, 7)), 16'($urandom()));
    // Keep the core running until the final phase.
    if (op == OP_PWR && sb.regs[s0] == PORT_HALT && sb.regs[s1] != 0) op = OP_OR;
    if ($urandom_range(0, 3) == 0) run_insn(op, d, s1, s0, 16'hFFFF);
    else run_insn(op, d, s1, s0, 16'($urandom()));
  endtask

  initial begin
    int          n;
    logic [15:0] c0, c1;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_D0_COUNT;
    cfg_wdata = '0;
    hold_req = 1'b0;
    burst_left = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: address extremes, every opcode, wrap, divide by zero, end of input.
    load_word(16'hFFFF, 16'hFFFF);
    load_word(16'h0000, 16'h0000);
    run_insn(OP_SET, 4'd1, 4'hF, 4'hF, 16'h0000);
    run_insn(OP_SET, 4'd2, 4'h0, 4'h3, 16'h0000);
    run_insn(OP_ADD, 4'd3, 4'd2, 4'd1, 16'h0000);
    run_insn(OP_SUB, 4'd4, 4'd1, 4'd2, 16'h0000);
    run_insn(OP_MUL, 4'd5, 4'd4, 4'd4, 16'h0000);
    run_insn(OP_DIV, 4'd6, 4'd2, 4'd1, 16'h0000);
    run_insn(OP_DIV, 4'd6, 4'd0, 4'd1, 16'h0000);
    run_insn(OP_SHL, 4'd7, 4'hF, 4'd1, 16'h0000);
    run_insn(OP_SHR, 4'd7, 4'hF, 4'd7, 16'h0000);
    run_insn(OP_AND, 4'd8, 4'd2, 4'd1, 16'h0000);
    run_insn(OP_OR,  4'd8, 4'd4, 4'd1, 16'h0000);
    run_insn(OP_NOT, 4'd10, 4'd0, 4'd0, 16'h0000);
    run_insn(OP_MOV, 4'd11, 4'd0, 4'd10, 16'h0000);
    run_insn(OP_STOR, 4'd0, 4'd3, 4'd10, 16'h0000);
    run_insn(OP_LOAD, 4'd12, 4'd0, 4'd10, 16'h0000);
    run_insn(OP_PRD, 4'd13, 4'd0, 4'd0, 16'hFFFF);
    run_insn(OP_PWR, 4'd0, 4'd1, 4'd0, 16'h0000);
    run_insn(OP_SET, 4'd9, 4'h0, 4'h1, 16'h0000);
    run_insn(OP_PWR, 4'd0, 4'd0, 4'd9, 16'h0000);
    run_insn(OP_PWR, 4'd0, 4'd1, 4'd2, 16'h0000);
    run_insn(OP_PRD, 4'd14, 4'd0, 4'd2, 16'h0000);
    run_insn(OP_JAL, 4'd15, 4'd0, 4'd10, 16'h0000);
    run_insn(OP_JAL, 4'd15, 4'd1, 4'd10, 16'h0000);
    step(16'h0000);

    // Random phases, each under its own disk count setting.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin c0 = 16'h0000; c1 = 16'hFFFF; end
        1: begin c0 = 16'hFFFF; c1 = 16'h0000; end
        2: begin c0 = 16'hFFFF; c1 = 16'hFFFF; end
        default: begin c0 = 16'($urandom()); c1 = 16'($urandom()); end
      endcase
      write_cfg(CFG_D0_COUNT, c0);
      write_cfg(CFG_D1_COUNT, c1);
      cfg_we <= 1'b0;
      if (ph == 1) hold_req = 1'b1;
      n = 0;
      while (n < 230) begin
        case ($urandom_range(0, 9))
          0: begin load_word(16'($urandom()), 16'($urandom())); n++; end
          1: begin step(16'($urandom())); n++; end
          default: begin random_insn(); n += 2; end
        endcase
      end
    end

    // Halt, then confirm steps do nothing while loads still land.
    run_insn(OP_SET, 4'd9, 4'h0, 4'h1, 16'h0000);
    run_insn(OP_SET, 4'd1, 4'h0, 4'h5, 16'h0000);
    run_insn(OP_PWR, 4'd0, 4'd1, 4'd9, 16'h0000);
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) step(16'($urandom()));
      else load_word(sb.pc, {OP_PWR, 4'd0, 4'd1, 4'd0});
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
